// ----- rtl/core/mfbr_pkg.sv -----
// Package for the MSB-first bit reader: ring geometry, field widths,
// operation and status codes. No dependencies.
package mfbr_pkg;

  // Ring geometry. RING_WORDS must be a power of two, at least 4.
  localparam int RING_WORDS = 16;
  localparam int WORD_W     = 64;
  localparam int RING_BITS  = RING_WORDS * WORD_W;
  localparam int POS_W      = $clog2(RING_BITS);
  localparam int FILL_W     = POS_W + 1;
  localparam int SUM_W      = FILL_W + 1;
  localparam int OFF_W      = $clog2(WORD_W);
  localparam int WORD_AW    = $clog2(RING_WORDS);
  localparam int BANK_DEPTH = RING_WORDS / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Field widths of the two channels.
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_READ   = 2'd1,
    OP_REWIND = 2'd2,
    OP_PUSH   = 2'd3
  } op_e_t;

  // Status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_NO_HIST   = 2'd2,
    ST_RING_FULL = 2'd3
  } status_e_t;

endpackage

// ----- rtl/core/msb_first_bit_reader.sv -----
// MSB-first bit reader over a ring of 64-bit words held in two memory banks.
// Depends on mfbr_pkg for geometry, widths and operation/status codes.
//
// Usage: each input beat carries op, count and data. Load stores data as the
// next 64 unread bits. Read returns count bits (1..64), first bit most
// significant, right-aligned. Rewind steps the cursor back over kept history.
// Push back places the low count bits of data just before the cursor so that
// they are read next. Load ignores count; for the others, counts above 64 act as 64 and a zero count is a no-op.
// A refused request reports its status and leaves the state unchanged.
// Every input beat gives exactly one output beat (value, status).
//
// Throughput is one beat per cycle unless out_stall holds a valid output:
// the bookkeeping counters update at acceptance, and the word pair under the
// bit position is read from the even and odd banks in that same edge, then
// merged or extracted and written back as the beat leaves the middle stage;
// a later beat reading that pair gets the written data forwarded.
// Reset clears the cursor, fill counters and pipeline valids; ring contents
// stay undefined until loaded. While out_stall holds a valid output, the
// output register and a full middle stage hold; in_stall rises until it moves.
module msb_first_bit_reader (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mfbr_pkg::OP_W-1:0]      in_op,
  input  logic [mfbr_pkg::COUNT_W-1:0]   in_count,
  input  logic [mfbr_pkg::WORD_W-1:0]    in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mfbr_pkg::WORD_W-1:0]    out_value,
  output logic [mfbr_pkg::STATUS_W-1:0]  out_status
);
  import mfbr_pkg::*;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_READ,
    KIND_WRITE
  } kind_t;

  // Work carried from acceptance to the read-modify-write stage.
  typedef struct packed {
    kind_t                kind;
    status_e_t            status;
    logic                 first_odd;
    logic [OFF_W-1:0]     off;
    logic [COUNT_W-1:0]   n;
    logic [WORD_W-1:0]    data;
    logic [BANK_AW-1:0]   even_addr;
    logic [BANK_AW-1:0]   odd_addr;
  } s1_info_t;

  localparam logic [SUM_W-1:0]   CAP_S      = SUM_W'(RING_BITS);
  localparam logic [COUNT_W-1:0] N_WORD     = COUNT_W'(WORD_W);
  localparam logic [FILL_W-1:0]  LOAD_LIMIT = FILL_W'(RING_BITS - WORD_W);

  // Memory banks: even-numbered and odd-numbered ring words.
  logic [WORD_W-1:0] mem_even [BANK_DEPTH];
  logic [WORD_W-1:0] mem_odd  [BANK_DEPTH];

  // Control state.
  logic [POS_W-1:0]  cursor_r, cursor_nxt;
  logic [FILL_W-1:0] ahead_r, ahead_nxt;
  logic [FILL_W-1:0] behind_r, behind_nxt;

  // Middle stage and read data.
  logic              s1_valid_r;
  s1_info_t          s1_r, s1_nxt;
  logic [WORD_W-1:0] rd_even_r, rd_odd_r;

  // Output register.
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_value_r;
  logic [STATUS_W-1:0] out_status_r;

  // Handshake.
  logic out_free, s1_fire, in_accept;
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Acceptance: check the request, update counters, pick the word pair.
  logic [COUNT_W-1:0] n_c;
  logic [FILL_W-1:0]  n_f;
  logic [POS_W-1:0]   pos;
  logic [WORD_AW-1:0] w0, w1;
  logic [FILL_W-1:0]  limit;

  always_comb begin
    n_c        = in_count[COUNT_W-1] ? N_WORD : in_count;
    n_f        = FILL_W'(n_c);
    cursor_nxt = cursor_r;
    ahead_nxt  = ahead_r;
    behind_nxt = behind_r;
    pos        = cursor_r;
    limit      = LOAD_LIMIT - ahead_r;
    s1_nxt.kind   = KIND_NONE;
    s1_nxt.status = ST_OK;
    s1_nxt.n      = n_c;
    s1_nxt.data   = in_data;
    unique case (op_e_t'(in_op))
      OP_LOAD: begin
        s1_nxt.n = N_WORD;
        pos      = cursor_r + ahead_r[POS_W-1:0];
        if ((SUM_W'(ahead_r) + SUM_W'(WORD_W)) > CAP_S) begin
          s1_nxt.status = ST_RING_FULL;
        end else begin
          s1_nxt.kind = KIND_WRITE;
          ahead_nxt   = ahead_r + FILL_W'(WORD_W);
          behind_nxt  = (behind_r > limit) ? limit : behind_r;
        end
      end
      OP_READ: begin
        if (n_c != '0) begin
          if (n_f > ahead_r) begin
            s1_nxt.status = ST_SHORT;
          end else begin
            s1_nxt.kind = KIND_READ;
            cursor_nxt  = cursor_r + n_f[POS_W-1:0];
            ahead_nxt   = ahead_r - n_f;
            behind_nxt  = behind_r + n_f;
          end
        end
      end
      OP_REWIND: begin
        if (n_c != '0) begin
          if (n_f > behind_r) begin
            s1_nxt.status = ST_NO_HIST;
          end else begin
            cursor_nxt = cursor_r - n_f[POS_W-1:0];
            ahead_nxt  = ahead_r + n_f;
            behind_nxt = behind_r - n_f;
          end
        end
      end
      OP_PUSH: begin
        pos = cursor_r - n_f[POS_W-1:0];
        if (n_c != '0) begin
          if ((SUM_W'(ahead_r) + SUM_W'(n_f)) > CAP_S) begin
            s1_nxt.status = ST_RING_FULL;
          end else begin
            s1_nxt.kind = KIND_WRITE;
            cursor_nxt  = pos;
            ahead_nxt   = ahead_r + n_f;
            behind_nxt  = (behind_r > n_f) ? behind_r - n_f : '0;
          end
        end
      end
      default: begin
        s1_nxt.kind = KIND_NONE;
      end
    endcase
    w0 = pos[POS_W-1:OFF_W];
    w1 = w0 + 1'b1;
    s1_nxt.first_odd = w0[0];
    s1_nxt.off       = pos[OFF_W-1:0];
    s1_nxt.odd_addr  = w0[WORD_AW-1:1];
    s1_nxt.even_addr = w0[0] ? w1[WORD_AW-1:1] : w0[WORD_AW-1:1];
  end

  // Middle stage: extract a field or merge new bits into the word pair.
  logic [2*WORD_W-1:0] win, win_sh, mask_w, dat_w, merged;
  logic [WORD_W-1:0]   m_top, d_top, all_ones, rd_val;
  logic [WORD_W-1:0]   wr_even_data, wr_odd_data;
  logic [COUNT_W-1:0]  rsh;
  logic                wr_en;

  always_comb begin
    all_ones = '1;
    rsh      = N_WORD - s1_r.n;
    win      = s1_r.first_odd ? {rd_odd_r, rd_even_r} : {rd_even_r, rd_odd_r};
    win_sh   = win << s1_r.off;
    rd_val   = win_sh[2*WORD_W-1:WORD_W] >> rsh;
    m_top    = ~(all_ones >> s1_r.n);
    d_top    = s1_r.data << rsh;
    mask_w   = {m_top, {WORD_W{1'b0}}} >> s1_r.off;
    dat_w    = {d_top, {WORD_W{1'b0}}} >> s1_r.off;
    merged   = (win & ~mask_w) | (dat_w & mask_w);
    wr_even_data = s1_r.first_odd ? merged[WORD_W-1:0] : merged[2*WORD_W-1:WORD_W];
    wr_odd_data  = s1_r.first_odd ? merged[2*WORD_W-1:WORD_W] : merged[WORD_W-1:0];
  end

  assign wr_en = s1_fire && (s1_r.kind == KIND_WRITE);

  // Banks: write back on leaving the middle stage, read at acceptance with
  // forwarding of a write to the same entry in the same edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_even[s1_r.even_addr] <= wr_even_data;
      mem_odd[s1_r.odd_addr]   <= wr_odd_data;
    end
    if (in_accept) begin
      rd_even_r <= (wr_en && (s1_r.even_addr == s1_nxt.even_addr)) ?
                   wr_even_data : mem_even[s1_nxt.even_addr];
      rd_odd_r  <= (wr_en && (s1_r.odd_addr == s1_nxt.odd_addr)) ?
                   wr_odd_data : mem_odd[s1_nxt.odd_addr];
      s1_r      <= s1_nxt;
    end
    if (s1_fire) begin
      out_value_r  <= (s1_r.kind == KIND_READ) ? rd_val : '0;
      out_status_r <= s1_r.status;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      ahead_r     <= '0;
      behind_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        cursor_r <= cursor_nxt;
        ahead_r  <= ahead_nxt;
        behind_r <= behind_nxt;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ----- sim/msb_first_bit_reader_test.sv -----
// Self-checking testbench for the MSB-first bit reader: loads, reads, rewinds and
// push-backs checked against a bit-level predictor of the word ring.
// Depends on mfbr_pkg and msb_first_bit_reader from the RTL tree.
`timescale 1ns / 1ps

module msb_first_bit_reader_test;
  import mfbr_pkg::*;

  localparam int RANDOM_REQS    = 850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 60;

  // One request beat and one result beat.
  typedef struct {
    op_e_t              op;
    logic [COUNT_W-1:0] count;
    logic [WORD_W-1:0]  data;
  } reader_req_t;

  typedef struct {
    logic [WORD_W-1:0] value;
    status_e_t         status;
  } field_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_op = OP_LOAD;
  logic [COUNT_W-1:0]  in_count = '0;
  logic [WORD_W-1:0]   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WORD_W-1:0]   out_value;
  logic [STATUS_W-1:0] out_status;

  reader_req_t   pending_reqs[$];
  field_result_t expected_fields[$];
  reader_req_t   live_req;

  // Predictor state: ring contents, cursor and fill counters.
  logic [WORD_W-1:0] ring_model [RING_WORDS];
  int cur_pos = 0;
  int fill_ahead = 0;
  int fill_behind = 0;

  // Fill counters that the stimulus generator tracks while planning.
  int plan_ahead = 0;
  int plan_behind = 0;

  int total_reqs = 0;
  int calm_after = 0;
  int beats_in = 0;
  int results_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int gap_in = 0;
  int gap_out = 0;
  int hold_out = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  bit long_hold_done = 1'b0;

  msb_first_bit_reader DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_count   (in_count),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

  always #5 clk = ~clk;

  function automatic logic ring_bit(int p);
    return ring_model[p / WORD_W][WORD_W - 1 - (p % WORD_W)];
  endfunction

  function automatic void set_ring_bit(int p, logic b);
    ring_model[p / WORD_W][WORD_W - 1 - (p % WORD_W)] = b;
  endfunction

  // Apply one request to the predictor state and return the result it gives.
  function automatic field_result_t next_field_result(reader_req_t req);
    field_result_t res;
    int n;
    int room;
    int p;
    int i;
    res.value = '0;
    res.status = ST_OK;
    n = (req.count > WORD_W) ? WORD_W : int'(req.count);
    case (req.op)
      OP_LOAD: begin
        if (fill_ahead + WORD_W > RING_BITS) begin
          res.status = ST_RING_FULL;
        end else begin
          // The oldest history gives way when free space is short.
          room = RING_BITS - fill_ahead - fill_behind;
          if (room < WORD_W) fill_behind -= WORD_W - room;
          p = (cur_pos + fill_ahead) % RING_BITS;
          for (i = 0; i < WORD_W; i++)
            set_ring_bit((p + i) % RING_BITS, req.data[WORD_W - 1 - i]);
          fill_ahead += WORD_W;
        end
      end
      OP_READ: begin
        if (n > fill_ahead) begin
          res.status = ST_SHORT;
        end else if (n != 0) begin
          for (i = 0; i < n; i++)
            res.value = {res.value[WORD_W-2:0], ring_bit((cur_pos + i) % RING_BITS)};
          cur_pos = (cur_pos + n) % RING_BITS;
          fill_ahead -= n;
          fill_behind += n;
        end
      end
      OP_REWIND: begin
        if (n > fill_behind) begin
          res.status = ST_NO_HIST;
        end else if (n != 0) begin
          cur_pos = (cur_pos + RING_BITS - n) % RING_BITS;
          fill_ahead += n;
          fill_behind -= n;
        end
      end
      default: begin
        if (fill_ahead + n > RING_BITS) begin
          res.status = ST_RING_FULL;
        end else if (n != 0) begin
          // Pushed bits land just before the cursor, over the nearest history.
          cur_pos = (cur_pos + RING_BITS - n) % RING_BITS;
          for (i = 0; i < n; i++)
            set_ring_bit((cur_pos + i) % RING_BITS, req.data[n - 1 - i]);
          fill_ahead += n;
          fill_behind = (fill_behind > n) ? fill_behind - n : 0;
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Queue a request and advance the planning counters the way the block will.
  task automatic queue_req(op_e_t op, int cnt, logic [WORD_W-1:0] data);
    reader_req_t req;
    int n;
    req.op = op;
    req.count = cnt[COUNT_W-1:0];
    req.data = data;
    pending_reqs.push_back(req);
    n = (req.count > WORD_W) ? WORD_W : int'(req.count);
    case (op)
      OP_LOAD: begin
        if (plan_ahead + WORD_W <= RING_BITS) begin
          if (RING_BITS - plan_ahead - plan_behind < WORD_W)
            plan_behind = RING_BITS - plan_ahead - WORD_W;
          plan_ahead += WORD_W;
        end
      end
      OP_READ: begin
        if (n <= plan_ahead) begin
          plan_ahead -= n;
          plan_behind += n;
        end
      end
      OP_REWIND: begin
        if (n <= plan_behind) begin
          plan_ahead += n;
          plan_behind -= n;
        end
      end
      default: begin
        if (plan_ahead + n <= RING_BITS) begin
          plan_ahead += n;
          plan_behind = (plan_behind > n) ? plan_behind - n : 0;
        end
      end
    endcase
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int k;
    int r;
    int n;
    int hi;
    int mode;
    int load_w;
    int read_w;
    int rew_w;
    op_e_t op;
    logic [WORD_W-1:0] data;

    // Refusals on an empty ring and zero counts.
    queue_req(OP_READ, 1, rand_word());
    queue_req(OP_REWIND, 1, rand_word());
    queue_req(OP_READ, 0, rand_word());
    queue_req(OP_REWIND, 0, rand_word());
    queue_req(OP_PUSH, 0, rand_word());
    // Loads ignore count; reads cross word boundaries; large counts act as 64.
    queue_req(OP_LOAD, 0, '1);
    queue_req(OP_LOAD, 127, '0);
    queue_req(OP_LOAD, 64, rand_word());
    queue_req(OP_READ, 1, rand_word());
    queue_req(OP_READ, 64, rand_word());
    queue_req(OP_READ, 127, rand_word());
    queue_req(OP_READ, 100, rand_word());
    queue_req(OP_REWIND, 127, rand_word());
    queue_req(OP_REWIND, 64, rand_word());
    queue_req(OP_REWIND, 2, rand_word());
    // Push-back over history, then read the pushed bits.
    queue_req(OP_PUSH, 64, rand_word());
    queue_req(OP_PUSH, 5, rand_word());
    queue_req(OP_READ, 5, rand_word());
    queue_req(OP_READ, 64, rand_word());
    // Fill the ring, then refuse a load and push back one bit to fill it exactly.
    while (plan_ahead + WORD_W <= RING_BITS) queue_req(OP_LOAD, 64, rand_word());
    queue_req(OP_LOAD, 64, rand_word());
    queue_req(OP_PUSH, 1, rand_word());
    // A load that drops history, then a push-back that is too large.
    queue_req(OP_READ, 64, rand_word());
    queue_req(OP_LOAD, 64, rand_word());
    queue_req(OP_PUSH, 64, '1);

    // Random part: phases favor filling, draining or a mix.
    mode = 2;
    for (k = 0; k < RANDOM_REQS; k++) begin
      if (k % 60 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_req(op_e_t'($urandom_range(0, 3)), $urandom_range(0, 127), rand_word());
      end else begin
        case (mode)
          0: begin load_w = 50; read_w = 25; rew_w = 10; end
          1: begin load_w = 10; read_w = 55; rew_w = 20; end
          default: begin load_w = 25; read_w = 40; rew_w = 15; end
        endcase
        r = $urandom_range(0, 99);
        if (r < load_w) op = OP_LOAD;
        else if (r < load_w + read_w) op = OP_READ;
        else if (r < load_w + read_w + rew_w) op = OP_REWIND;
        else op = OP_PUSH;
        if (op == OP_REWIND && plan_behind == 0) op = OP_READ;
        if (op == OP_PUSH && plan_ahead == RING_BITS) op = OP_READ;
        if (op == OP_READ && plan_ahead == 0) op = OP_LOAD;
        data = rand_word();
        case (op)
          OP_LOAD: begin
            r = $urandom_range(0, 15);
            if (r == 0) data = '0;
            else if (r == 1) data = '1;
            n = $urandom_range(0, 127);
          end
          OP_READ: begin
            hi = (plan_ahead < WORD_W) ? plan_ahead : WORD_W;
            if (hi < WORD_W && $urandom_range(0, 9) == 0) n = $urandom_range(hi + 1, WORD_W);
            else n = $urandom_range(1, hi);
          end
          OP_REWIND: begin
            hi = (plan_behind < WORD_W) ? plan_behind : WORD_W;
            if (hi < WORD_W && $urandom_range(0, 9) == 0) n = $urandom_range(hi + 1, WORD_W);
            else n = $urandom_range(1, hi);
          end
          default: begin
            hi = RING_BITS - plan_ahead;
            if (hi > WORD_W) hi = WORD_W;
            if (hi < WORD_W && $urandom_range(0, 9) == 0) n = $urandom_range(hi + 1, WORD_W);
            else n = $urandom_range(1, hi);
          end
        endcase
        // Counts above 64 stand in for 64 now and then.
        if (op != OP_LOAD && n == WORD_W && $urandom_range(0, 3) == 0)
          n = $urandom_range(65, 127);
        queue_req(op, n, data);
      end
    end
    total_reqs = pending_reqs.size();
    calm_after = total_reqs * 85 / 100;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (beats_in == total_reqs);
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("msb_first_bit_reader verification clean");
    end else begin
      $display("msb_first_bit_reader verification failed");
    end
    $finish;
  end

  // Request driver: predicts each accepted beat, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_fields.push_back(next_field_result(live_req));
        beats_in++;
      end
      if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
      if (!in_valid || !in_stall) begin
        if (gap_in > 0) begin
          gap_in--;
          in_valid <= 1'b0;
        end else if (!calm_in && beats_in < calm_after && $urandom_range(0, 5) == 0) begin
          gap_in = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          live_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= live_req.op;
          in_count <= live_req.count;
          in_data <= live_req.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted beat and drives out_stall.
  always @(posedge clk) begin
    field_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_fields.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time, out_value, out_status);
          mismatches++;
        end else begin
          want = expected_fields.pop_front();
          if (out_value !== want.value) begin
            $display("%0t: value mismatch expected=%h actual=%h", $time, want.value, out_value);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, want.status, out_status);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      // One long hold-off backs the pipeline up into the input channel.
      if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1'b1;
        hold_out = LONG_HOLD;
      end
      if (hold_out > 0) begin
        hold_out--;
        out_stall <= 1'b1;
      end else if (gap_out > 0) begin
        gap_out--;
        out_stall <= 1'b1;
      end else if (!calm_out && results_seen < calm_after && $urandom_range(0, 5) == 0) begin
        gap_out = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("msb_first_bit_reader verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
